FILE: hdl/connection_slot_pool_allocator_unit_macros.svh
// Assertion helpers used by the allocator top level.
`ifndef CONNECTION_SLOT_POOL_ALLOCATOR_UNIT_MACROS_SVH
`define CONNECTION_SLOT_POOL_ALLOCATOR_UNIT_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define CSPA_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define CSPA_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hdl/cspa_pkg.sv
// ----------------------------------------------------------------------------
// cspa_pkg
// Types, codes and sizes shared by the slot pool allocator.
// ----------------------------------------------------------------------------
package cspa_pkg;

    localparam int SLOTS      = 16;
    localparam int SLOT_W     = 4;
    localparam int CNT_W      = 5;
    localparam int ID_W       = 16;
    localparam int TIME_W     = 32;
    localparam int USES_W     = 16;
    localparam int WORD_W     = ID_W + TIME_W + USES_W;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;
    localparam int PCT_W      = 7;
    localparam int PROD_W     = 13;

    localparam logic [USES_W-1:0] USES_MAX = '1;

    typedef enum logic [1:0] {
        OP_INIT    = 2'd0,
        OP_ACQUIRE = 2'd1,
        OP_RELEASE = 2'd2,
        OP_TICK    = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        RES_OK         = 2'd0,
        RES_NONE       = 2'd1,
        RES_NOT_FOUND  = 2'd2,
        RES_NOT_ACTIVE = 2'd3
    } t_res;

    typedef enum logic [1:0] {
        SL_IDLE    = 2'd0,
        SL_ACTIVE  = 2'd1,
        SL_COOLING = 2'd2
    } t_slot;

    typedef enum logic [1:0] {
        STRAT_FIRST = 2'd0,
        STRAT_LAST  = 2'd1,
        STRAT_LRU   = 2'd2,
        STRAT_RR    = 2'd3
    } t_strategy;

    typedef enum logic [1:0] {
        SCAN_FREE = 2'd0,
        SCAN_COOL = 2'd1,
        SCAN_ID   = 2'd2,
        SCAN_DOWN = 2'd3
    } t_scan;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_STRATEGY  = 3'd0,
        REG_INIT_SIZE = 3'd1,
        REG_MIN_SIZE  = 3'd2,
        REG_MAX_SIZE  = 3'd3,
        REG_IDLE_TO   = 3'd4,
        REG_MAX_REQ   = 3'd5,
        REG_COOLDOWN  = 3'd6,
        REG_SCALE_PCT = 3'd7
    } t_reg;

    typedef struct packed {
        logic      start;
        logic      init;
        logic      tick;
        logic      rr_prep;
        logic      rr_step;
        logic      scan_start;
        t_scan     scan_kind;
        logic      rd_pick;
        logic      rd_last;
        logic      grow;
        logic      acq_write;
        logic      rel_write;
        logic      move_write;
        logic      shrink;
        logic      keep_slot;
        logic      set_res;
        t_res      res_code;
        logic      load_out;
    } t_cmd;

    typedef struct packed {
        t_op  op;
        logic strat_rr;
        logic n_zero;
        logic base_ok;
        logic scan_done;
        logic scan_hit;
        logic can_grow;
        logic pick_active;
        logic scale_ok;
        logic move_needed;
        logic out_free;
    } t_stat;

endpackage

FILE: hdl/cspa_ifs.sv
// ----------------------------------------------------------------------------
// cspa interfaces
// Request, result and register write channels of the slot pool allocator.
// ----------------------------------------------------------------------------
interface cspa_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  op;
    logic [15:0] conn_id;
    logic        hard_close;
    modport source (output valid, op, conn_id, hard_close, input ready);
    modport sink   (input valid, op, conn_id, hard_close, output ready);
endinterface

interface cspa_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [3:0]  slot;
    logic [15:0] granted_id;
    logic [4:0]  pool_size_now;
    logic [4:0]  active_now;
    modport source (output valid, status, slot, granted_id, pool_size_now, active_now,
                    input ready);
    modport sink   (input valid, status, slot, granted_id, pool_size_now, active_now,
                    output ready);
endinterface

interface cspa_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [31:0] data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

FILE: hdl/cspa_ram.sv
// ----------------------------------------------------------------------------
// cspa_ram
// Generic one-write, one-read RAM with registered read data.
// ----------------------------------------------------------------------------
module cspa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: hdl/cspa_ctrl.sv
// ----------------------------------------------------------------------------
// cspa_ctrl
// Sequencer: walks each operation through its scans, reads and writes.
// ----------------------------------------------------------------------------
module cspa_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  cspa_pkg::t_stat  i_stat,
    output logic             o_in_ready,
    output cspa_pkg::t_cmd   o_cmd
);

    typedef enum logic [14:0] {
        S_IDLE     = 15'h0001,
        S_EXEC     = 15'h0002,
        S_RRMOD    = 15'h0004,
        S_FREE     = 15'h0008,
        S_COOL     = 15'h0010,
        S_ACQ_RD   = 15'h0020,
        S_ACQ_WR   = 15'h0040,
        S_REL_SCAN = 15'h0080,
        S_REL_RD   = 15'h0100,
        S_REL_WR   = 15'h0200,
        S_SCALE    = 15'h0400,
        S_DOWN     = 15'h0800,
        S_MV_RD    = 15'h1000,
        S_MV_WR    = 15'h2000,
        S_DONE     = 15'h4000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_ready = (r_state == S_IDLE);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.start = 1'b1;
                    n_state     = S_EXEC;
                end
            end
            S_EXEC: begin
                unique case (i_stat.op)
                    cspa_pkg::OP_INIT: begin
                        o_cmd.init = 1'b1;
                        n_state    = S_DONE;
                    end
                    cspa_pkg::OP_TICK: begin
                        o_cmd.tick = 1'b1;
                        n_state    = S_DONE;
                    end
                    cspa_pkg::OP_ACQUIRE: begin
                        if (i_stat.strat_rr && !i_stat.n_zero) begin
                            o_cmd.rr_prep = 1'b1;
                            n_state       = S_RRMOD;
                        end else begin
                            o_cmd.scan_start = 1'b1;
                            o_cmd.scan_kind  = cspa_pkg::SCAN_FREE;
                            n_state          = S_FREE;
                        end
                    end
                    cspa_pkg::OP_RELEASE: begin
                        o_cmd.scan_start = 1'b1;
                        o_cmd.scan_kind  = cspa_pkg::SCAN_ID;
                        n_state          = S_REL_SCAN;
                    end
                    default: n_state = S_DONE;
                endcase
            end
            S_RRMOD: begin
                if (i_stat.base_ok) begin
                    o_cmd.scan_start = 1'b1;
                    o_cmd.scan_kind  = cspa_pkg::SCAN_FREE;
                    n_state          = S_FREE;
                end else begin
                    o_cmd.rr_step = 1'b1;
                end
            end
            S_FREE: begin
                if (i_stat.scan_done) begin
                    if (i_stat.scan_hit) begin
                        n_state = S_ACQ_RD;
                    end else begin
                        o_cmd.scan_start = 1'b1;
                        o_cmd.scan_kind  = cspa_pkg::SCAN_COOL;
                        n_state          = S_COOL;
                    end
                end
            end
            S_COOL: begin
                if (i_stat.scan_done) begin
                    if (i_stat.scan_hit) begin
                        n_state = S_ACQ_RD;
                    end else if (i_stat.can_grow) begin
                        o_cmd.grow = 1'b1;
                        n_state    = S_ACQ_RD;
                    end else begin
                        o_cmd.set_res  = 1'b1;
                        o_cmd.res_code = cspa_pkg::RES_NONE;
                        n_state        = S_DONE;
                    end
                end
            end
            S_ACQ_RD: begin
                o_cmd.rd_pick = 1'b1;
                n_state       = S_ACQ_WR;
            end
            S_ACQ_WR: begin
                o_cmd.acq_write = 1'b1;
                o_cmd.keep_slot = 1'b1;
                n_state         = S_DONE;
            end
            S_REL_SCAN: begin
                if (i_stat.scan_done) begin
                    if (!i_stat.scan_hit) begin
                        o_cmd.set_res  = 1'b1;
                        o_cmd.res_code = cspa_pkg::RES_NOT_FOUND;
                        n_state        = S_DONE;
                    end else if (!i_stat.pick_active) begin
                        o_cmd.set_res   = 1'b1;
                        o_cmd.res_code  = cspa_pkg::RES_NOT_ACTIVE;
                        o_cmd.keep_slot = 1'b1;
                        n_state         = S_DONE;
                    end else begin
                        n_state = S_REL_RD;
                    end
                end
            end
            S_REL_RD: begin
                o_cmd.rd_pick = 1'b1;
                n_state       = S_REL_WR;
            end
            S_REL_WR: begin
                o_cmd.rel_write = 1'b1;
                o_cmd.keep_slot = 1'b1;
                n_state         = S_SCALE;
            end
            S_SCALE: begin
                if (i_stat.scale_ok) begin
                    o_cmd.scan_start = 1'b1;
                    o_cmd.scan_kind  = cspa_pkg::SCAN_DOWN;
                    n_state          = S_DOWN;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_DOWN: begin
                if (i_stat.scan_done) begin
                    if (!i_stat.scan_hit) begin
                        n_state = S_DONE;
                    end else if (i_stat.move_needed) begin
                        n_state = S_MV_RD;
                    end else begin
                        o_cmd.shrink = 1'b1;
                        n_state      = S_DONE;
                    end
                end
            end
            S_MV_RD: begin
                o_cmd.rd_last = 1'b1;
                n_state       = S_MV_WR;
            end
            S_MV_WR: begin
                o_cmd.move_write = 1'b1;
                o_cmd.shrink     = 1'b1;
                n_state          = S_DONE;
            end
            S_DONE: begin
                if (i_stat.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

endmodule

FILE: hdl/cspa_dpath.sv
// ----------------------------------------------------------------------------
// cspa_dpath
// Slot table, scan engine, counters, registers and result word.
// ----------------------------------------------------------------------------
module cspa_dpath (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  cspa_pkg::t_cmd                     i_cmd,
    output cspa_pkg::t_stat                    o_stat,
    input  logic [1:0]                         i_op,
    input  logic [cspa_pkg::ID_W-1:0]          i_conn_id,
    input  logic                               i_hard_close,
    input  logic                               i_cfg_valid,
    input  logic [cspa_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [cspa_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    output logic                               o_valid,
    input  logic                               i_ready,
    output logic [1:0]                         o_status,
    output logic [cspa_pkg::SLOT_W-1:0]        o_slot,
    output logic [cspa_pkg::ID_W-1:0]          o_granted_id,
    output logic [cspa_pkg::CNT_W-1:0]         o_pool_size_now,
    output logic [cspa_pkg::CNT_W-1:0]         o_active_now
);

    localparam int SW = cspa_pkg::SLOT_W;
    localparam int CW = cspa_pkg::CNT_W;
    localparam int TW = cspa_pkg::TIME_W;
    localparam int IW = cspa_pkg::ID_W;
    localparam int UW = cspa_pkg::USES_W;

    // Registers
    cspa_pkg::t_strategy    r_strat;
    logic [CW-1:0]          r_init_size, r_min, r_max;
    logic [TW-1:0]          r_idle_to, r_cooldown;
    logic [UW-1:0]          r_max_req;
    logic [cspa_pkg::PCT_W-1:0] r_thr;

    // Pool state
    cspa_pkg::t_slot        r_state [cspa_pkg::SLOTS];
    logic                   r_conn  [cspa_pkg::SLOTS];
    logic [CW-1:0]          r_pool, r_active, r_base;
    logic [SW-1:0]          r_rr;
    logic [TW-1:0]          r_now;
    logic [IW-1:0]          r_next_id;

    // Captured request
    cspa_pkg::t_op          r_op;
    logic [IW-1:0]          r_cid;
    logic                   r_force;

    // Scan engine
    cspa_pkg::t_scan        r_kind;
    logic                   r_scan, r_pv, r_hit;
    logic [CW-1:0]          r_cnt;
    logic [SW-1:0]          r_pidx, r_pick;
    logic [TW-1:0]          r_best;

    // Result
    cspa_pkg::t_res         r_rstat;
    logic [SW-1:0]          r_rslot;
    logic [IW-1:0]          r_rgid;
    logic                   r_ovalid;
    logic [1:0]             r_ostat;
    logic [SW-1:0]          r_oslot;
    logic [IW-1:0]          r_ogid;
    logic [CW-1:0]          r_opool, r_oact;

    // RAM port
    logic                         w_we;
    logic [SW-1:0]                w_waddr, w_raddr;
    logic [cspa_pkg::WORD_W-1:0]  w_wdata, w_q;

    cspa_ram #(
        .WIDTH (cspa_pkg::WORD_W),
        .DEPTH (cspa_pkg::SLOTS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_q)
    );

    // Raw RAM fields, and fields masked to zero for a slot without connection
    logic [IW-1:0] q_id;
    logic [TW-1:0] q_last;
    logic [UW-1:0] q_uses;
    assign {q_id, q_last, q_uses} = w_q;

    logic          ev_conn;
    cspa_pkg::t_slot ev_state;
    logic [IW-1:0] ev_id;
    logic [TW-1:0] ev_last, ev_age;
    assign ev_conn  = r_conn[r_pidx];
    assign ev_state = r_state[r_pidx];
    assign ev_id    = ev_conn ? q_id : '0;
    assign ev_last  = ev_conn ? q_last : '0;
    assign ev_age   = r_now - ev_last;

    logic          stop_kind, issue, scan_done;
    logic [CW-1:0] idx_full, rr_sum, last_full;
    assign last_full = r_pool - CW'(1);
    assign stop_kind = !(r_kind == cspa_pkg::SCAN_FREE && r_strat == cspa_pkg::STRAT_LRU);
    assign issue     = r_scan && (r_cnt < r_pool) && !(r_hit && stop_kind);
    assign scan_done = r_scan && ((r_hit && stop_kind) || (r_cnt == r_pool && !r_pv));
    assign rr_sum    = r_base + r_cnt;

    always_comb begin
        idx_full = r_cnt;
        unique case (r_kind)
            cspa_pkg::SCAN_FREE: begin
                case (r_strat)
                    cspa_pkg::STRAT_LAST: idx_full = last_full - r_cnt;
                    cspa_pkg::STRAT_RR:   idx_full = (rr_sum >= r_pool) ? rr_sum - r_pool
                                                                       : rr_sum;
                    default:              idx_full = r_cnt;
                endcase
            end
            cspa_pkg::SCAN_DOWN: idx_full = last_full - r_cnt;
            default:             idx_full = r_cnt;
        endcase
    end

    // Evaluate the entry whose read data has just arrived
    logic ev_match, ev_lru_take;
    always_comb begin
        ev_match    = 1'b0;
        ev_lru_take = 1'b0;
        unique case (r_kind)
            cspa_pkg::SCAN_FREE: begin
                if (r_strat == cspa_pkg::STRAT_LRU) begin
                    ev_lru_take = (ev_state == cspa_pkg::SL_IDLE) &&
                                  (!r_hit || ev_age > r_best);
                end else begin
                    ev_match = (ev_state == cspa_pkg::SL_IDLE);
                end
            end
            cspa_pkg::SCAN_COOL:
                ev_match = (ev_state == cspa_pkg::SL_COOLING) && (ev_age >= r_cooldown);
            cspa_pkg::SCAN_ID:
                ev_match = ev_conn && (ev_id == r_cid);
            cspa_pkg::SCAN_DOWN:
                ev_match = (ev_state == cspa_pkg::SL_IDLE) ||
                           (ev_state == cspa_pkg::SL_COOLING);
            default: ev_match = 1'b0;
        endcase
    end

    logic ev_act;
    assign ev_act = r_scan && r_pv && !(r_hit && stop_kind);

    // Acquire and release word updates
    logic          acq_fresh;
    logic [IW-1:0] acq_id;
    logic [UW-1:0] acq_base, acq_uses;
    assign acq_fresh = !r_conn[r_pick];
    assign acq_id    = acq_fresh ? r_next_id : q_id;
    assign acq_base  = acq_fresh ? '0 : q_uses;
    assign acq_uses  = (acq_base == cspa_pkg::USES_MAX) ? acq_base : acq_base + UW'(1);

    logic [TW-1:0] held;
    logic          rel_close;
    assign held      = r_now - q_last;
    assign rel_close = r_force ||
                       (r_max_req != '0 && q_uses >= r_max_req) ||
                       (r_idle_to != '0 && held >= r_idle_to);

    always_comb begin
        w_we    = 1'b0;
        w_waddr = r_pick;
        w_wdata = w_q;
        if (i_cmd.acq_write) begin
            w_we    = 1'b1;
            w_wdata = {acq_id, r_now, acq_uses};
        end else if (i_cmd.rel_write && rel_close) begin
            w_we    = 1'b1;
            w_wdata = {r_next_id, r_now, UW'(0)};
        end else if (i_cmd.move_write) begin
            w_we    = 1'b1;
        end
    end

    always_comb begin
        if (i_cmd.rd_pick) begin
            w_raddr = r_pick;
        end else if (i_cmd.rd_last) begin
            w_raddr = last_full[SW-1:0];
        end else begin
            w_raddr = idx_full[SW-1:0];
        end
    end

    // Scale-down test on the count after release
    logic [cspa_pkg::PROD_W-1:0] lhs, rhs;
    assign lhs = cspa_pkg::PROD_W'(r_active) * cspa_pkg::PROD_W'(200);
    assign rhs = cspa_pkg::PROD_W'(r_thr) * cspa_pkg::PROD_W'(r_pool);

    always_comb begin
        o_stat             = '0;
        o_stat.op          = r_op;
        o_stat.strat_rr    = (r_strat == cspa_pkg::STRAT_RR);
        o_stat.n_zero      = (r_pool == '0);
        o_stat.base_ok     = (r_base < r_pool);
        o_stat.scan_done   = scan_done;
        o_stat.scan_hit    = r_hit;
        o_stat.can_grow    = (r_pool < r_max) && (r_pool < CW'(cspa_pkg::SLOTS));
        o_stat.pick_active = (r_state[r_pick] == cspa_pkg::SL_ACTIVE);
        o_stat.scale_ok    = (r_thr != '0) && (lhs < rhs) && (r_pool > r_min);
        o_stat.move_needed = ({1'b0, r_pick} < last_full);
        o_stat.out_free    = !r_ovalid || i_ready;
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strat     <= cspa_pkg::STRAT_LRU;
            r_init_size <= CW'(4);
            r_min       <= CW'(2);
            r_max       <= CW'(16);
            r_idle_to   <= TW'(300000);
            r_max_req   <= UW'(1000);
            r_cooldown  <= TW'(1000);
            r_thr       <= cspa_pkg::PCT_W'(75);
            for (int i = 0; i < cspa_pkg::SLOTS; i++) begin
                r_state[i] <= cspa_pkg::SL_IDLE;
                r_conn[i]  <= 1'b0;
            end
            r_pool    <= '0;
            r_active  <= '0;
            r_rr      <= '0;
            r_now     <= '0;
            r_next_id <= '0;
            r_scan    <= 1'b0;
            r_pv      <= 1'b0;
            r_hit     <= 1'b0;
            r_ovalid  <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                unique case (cspa_pkg::t_reg'(i_cfg_index))
                    cspa_pkg::REG_STRATEGY:  r_strat     <= cspa_pkg::t_strategy'(i_cfg_data[1:0]);
                    cspa_pkg::REG_INIT_SIZE: r_init_size <= i_cfg_data[CW-1:0];
                    cspa_pkg::REG_MIN_SIZE:  r_min       <= i_cfg_data[CW-1:0];
                    cspa_pkg::REG_MAX_SIZE:  r_max       <= i_cfg_data[CW-1:0];
                    cspa_pkg::REG_IDLE_TO:   r_idle_to   <= i_cfg_data[TW-1:0];
                    cspa_pkg::REG_MAX_REQ:   r_max_req   <= i_cfg_data[UW-1:0];
                    cspa_pkg::REG_COOLDOWN:  r_cooldown  <= i_cfg_data[TW-1:0];
                    cspa_pkg::REG_SCALE_PCT: r_thr       <= i_cfg_data[cspa_pkg::PCT_W-1:0];
                    default: ;
                endcase
            end

            if (i_cmd.init) begin
                for (int i = 0; i < cspa_pkg::SLOTS; i++) begin
                    r_state[i] <= cspa_pkg::SL_IDLE;
                    r_conn[i]  <= 1'b0;
                end
                r_pool   <= (r_init_size > CW'(cspa_pkg::SLOTS)) ? CW'(cspa_pkg::SLOTS)
                                                                : r_init_size;
                r_active <= '0;
                r_rr     <= '0;
            end
            if (i_cmd.tick) begin
                r_now <= r_now + TW'(1);
            end

            // Scan engine
            if (i_cmd.scan_start) begin
                r_scan <= 1'b1;
                r_pv   <= 1'b0;
                r_hit  <= 1'b0;
            end else if (r_scan) begin
                if (scan_done) begin
                    r_scan <= 1'b0;
                end
                r_pv <= issue;
                if (ev_act && (ev_match || ev_lru_take)) begin
                    r_hit <= 1'b1;
                    if (r_kind == cspa_pkg::SCAN_FREE && r_strat == cspa_pkg::STRAT_RR) begin
                        r_rr <= ({1'b0, r_pidx} + CW'(1) == r_pool) ? '0 : r_pidx + SW'(1);
                    end
                end
            end

            if (i_cmd.grow) begin
                r_pool <= r_pool + CW'(1);
            end

            if (i_cmd.acq_write) begin
                r_conn[r_pick]  <= 1'b1;
                r_state[r_pick] <= cspa_pkg::SL_ACTIVE;
                r_active        <= r_active + CW'(1);
                if (acq_fresh) begin
                    r_next_id <= r_next_id + IW'(1);
                end
            end

            if (i_cmd.rel_write) begin
                if (rel_close) begin
                    r_state[r_pick] <= cspa_pkg::SL_IDLE;
                    r_next_id       <= r_next_id + IW'(1);
                end else begin
                    r_state[r_pick] <= (r_cooldown != '0) ? cspa_pkg::SL_COOLING
                                                          : cspa_pkg::SL_IDLE;
                end
                if (r_active != '0) begin
                    r_active <= r_active - CW'(1);
                end
            end

            // Move the top slot down, then retire it
            if (i_cmd.move_write) begin
                r_state[r_pick] <= r_state[last_full[SW-1:0]];
                r_conn[r_pick]  <= r_conn[last_full[SW-1:0]];
            end
            if (i_cmd.shrink) begin
                r_state[last_full[SW-1:0]] <= cspa_pkg::SL_IDLE;
                r_conn[last_full[SW-1:0]]  <= 1'b0;
                r_pool                     <= last_full;
            end

            if (i_cmd.load_out) begin
                r_ovalid <= 1'b1;
            end else if (i_ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_op    <= cspa_pkg::t_op'(i_op);
            r_cid   <= i_conn_id;
            r_force <= i_hard_close;
            r_rstat <= cspa_pkg::RES_OK;
            r_rslot <= '0;
            r_rgid  <= '0;
        end
        if (i_cmd.set_res) begin
            r_rstat <= i_cmd.res_code;
        end
        if (i_cmd.keep_slot) begin
            r_rslot <= r_pick;
        end
        if (i_cmd.acq_write) begin
            r_rgid <= acq_id;
        end
        if (i_cmd.rr_prep) begin
            r_base <= {1'b0, r_rr};
        end else if (i_cmd.rr_step) begin
            r_base <= r_base - r_pool;
        end
        if (i_cmd.scan_start) begin
            r_kind <= i_cmd.scan_kind;
            r_cnt  <= '0;
        end else if (issue) begin
            r_cnt <= r_cnt + CW'(1);
        end
        if (r_scan) begin
            r_pidx <= idx_full[SW-1:0];
        end
        if (ev_act && (ev_match || ev_lru_take)) begin
            r_pick <= r_pidx;
            r_best <= ev_age;
        end
        if (i_cmd.grow) begin
            r_pick <= r_pool[SW-1:0];
        end
        if (i_cmd.load_out) begin
            r_ostat <= r_rstat;
            r_oslot <= r_rslot;
            r_ogid  <= r_rgid;
            r_opool <= r_pool;
            r_oact  <= r_active;
        end
    end

    assign o_valid         = r_ovalid;
    assign o_status        = r_ostat;
    assign o_slot          = r_oslot;
    assign o_granted_id    = r_ogid;
    assign o_pool_size_now = r_opool;
    assign o_active_now    = r_oact;

endmodule

FILE: hdl/connection_slot_pool_allocator_unit.sv
// ----------------------------------------------------------------------------
// connection_slot_pool_allocator_unit
// Connection slot pool: init, acquire, release and millisecond tick.
// ----------------------------------------------------------------------------
// Usage:
//   i_in carries one request word (op, conn_id, hard_close); o_out returns
//   exactly one result word per request (status, slot, granted_id, pool size
//   and active count after the operation). i_cfg writes the eight registers
//   by index; it is always ready. The user must see that it is written only
//   while the unit is idle; the unit itself does not enforce this.
//   One request is worked at a time. Init and tick go from the exec state
//   to the done state, which loads their result. Acquire and release walk
//   the slot table one entry per cycle through the single read port of the
//   slot RAM: acquire runs a free scan, then a cooled-slot scan; release an
//   id search, then a scale-down scan from the top and a move of the top
//   slot. Round-robin first folds the stored pointer back into the pool,
//   one whole pool length per step, before the free scan starts.
//   The result sits in an output register; the next request is taken while
//   it waits, and finishing work stalls until the receiver takes it.
//   Reset empties the pool, zeroes the clock and id counter and loads the
//   register defaults; no clearing pass is needed.
// ----------------------------------------------------------------------------
`include "connection_slot_pool_allocator_unit_macros.svh"

module connection_slot_pool_allocator_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    cspa_in_if.sink     i_in,
    cspa_out_if.source  o_out,
    cspa_cfg_if.sink    i_cfg
);

    cspa_pkg::t_cmd  w_cmd;
    cspa_pkg::t_stat w_stat;
    logic            w_in_ready;

    // Sequencer: owns the operation flow
    cspa_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .i_stat     (w_stat),
        .o_in_ready (w_in_ready),
        .o_cmd      (w_cmd)
    );

    // Datapath: slot table, scan engine and the result register
    cspa_dpath u_dpath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (w_cmd),
        .o_stat          (w_stat),
        .i_op            (i_in.op),
        .i_conn_id       (i_in.conn_id),
        .i_hard_close    (i_in.hard_close),
        .i_cfg_valid     (i_cfg.valid),
        .i_cfg_index     (i_cfg.index),
        .i_cfg_data      (i_cfg.data),
        .o_valid         (o_out.valid),
        .i_ready         (o_out.ready),
        .o_status        (o_out.status),
        .o_slot          (o_out.slot),
        .o_granted_id    (o_out.granted_id),
        .o_pool_size_now (o_out.pool_size_now),
        .o_active_now    (o_out.active_now)
    );

    assign i_in.ready  = w_in_ready;
    assign i_cfg.ready = 1'b1;

    // Never overwrite a result the receiver has not taken
    `CSPA_ASSERT_NOW(a_load_free, w_cmd.load_out, !o_out.valid || o_out.ready, "result overwritten")
    // One request in flight: drop ready right after an accept
    `CSPA_ASSERT_NEXT(a_one_flight, i_in.valid && w_in_ready, !w_in_ready, "second request taken")
    // Active slots never outnumber the pool
    `CSPA_ASSERT_NOW(a_active_le_pool, o_out.valid, o_out.active_now <= o_out.pool_size_now, "active above pool size")

endmodule
